### src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int IDENT_W   = 16;
	localparam int PRIO_W    = 16;
	localparam int COUNT_W   = 5;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_POP    = 2'd1,
		MODE_PEEK   = 2'd2,
		MODE_FIND   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2
	} cell_op_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		cell_op_t                   op;
		logic [IDENT_W-1:0]         ident;
		logic signed [PRIO_W-1:0]   prio;
	} cell_ctrl_t;

endpackage
`default_nettype wire

### src/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts it toward a neighbor.
`default_nettype none
module spq_cell (
	input  wire logic                              clk,
	input  wire spq_pkg::cell_ctrl_t               ctrl,
	input  wire logic                              occupied,
	input  wire logic                              left_ge,
	input  wire logic [spq_pkg::IDENT_W-1:0]       left_ident,
	input  wire logic signed [spq_pkg::PRIO_W-1:0] left_prio,
	input  wire logic [spq_pkg::IDENT_W-1:0]       right_ident,
	input  wire logic signed [spq_pkg::PRIO_W-1:0] right_prio,
	output logic                                   ge,
	output logic                                   hit,
	output logic [spq_pkg::IDENT_W-1:0]            ident,
	output logic signed [spq_pkg::PRIO_W-1:0]      prio
);
	import spq_pkg::*;

	logic [IDENT_W-1:0]       ident_q;
	logic signed [PRIO_W-1:0] prio_q;

	// An empty slot counts as lower than any new entry, so the insert point is
	// always found at or before the first free slot.
	assign ge    = !occupied || (ctrl.prio >= prio_q);
	assign hit   = occupied && (ident_q == ctrl.ident);
	assign ident = ident_q;
	assign prio  = prio_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (ge && !left_ge) begin
					ident_q <= ctrl.ident;
					prio_q  <= ctrl.prio;
				end else if (ge) begin
					ident_q <= left_ident;
					prio_q  <= left_prio;
				end
			end
			OP_POP: begin
				ident_q <= right_ident;
				prio_q  <= right_prio;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### src/sorted_priority_queue.sv
// Top level of the sorted priority queue: chain of entry cells and result register.
// The queue keeps up to DEPTH entries sorted by descending priority in a row of
// cells; slot 0 is the head. Every cell compares the incoming priority in the
// same cycle, so an insert or a pop shifts the whole row together.
// Input beat: s_tuser carries the request kind (insert, pop, peek, contains),
// s_tdata the identity and priority. Each request gives exactly one output beat
// with the head entry (pop and peek only), a status code, the contains flag, the
// entry count after the request and an empty flag.
// The output beat follows in the cycle after an accepted input beat. One
// request is taken per cycle while the output is not held; the rate is set by the
// row's parallel compare and shift plus the identity match OR across all cells.
// The output beat is held in a register; while it waits on m_tready the block
// takes no new request (s_tready is low), and nothing inside changes.
// Reset empties the queue and clears the output valid; the stored entries are
// not cleared, slots beyond the count are simply never shown.
`default_nettype none
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // ident[15:0], prio[31:16]
	input  wire logic [1:0]  s_tuser,   // mode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// head_ident[15:0], head_prio[31:16], status[33:32], found[34],
	// entry_count[39:35], queue_empty[40], zero fill[47:41]
	output logic [47:0]      m_tdata
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             m_valid_q;
	logic [47:0]      m_data_q;

	logic                     accept;
	mode_t                    mode;
	logic                     is_full;
	logic                     no_entries;
	cell_ctrl_t               ctrl;
	logic                     found;
	status_t                  status;
	logic [IDENT_W-1:0]       head_ident;
	logic [PRIO_W-1:0]        head_prio;

	logic [IDENT_W-1:0]       cell_ident [DEPTH];
	logic signed [PRIO_W-1:0] cell_prio  [DEPTH];
	logic [DEPTH-1:0]         cell_ge;
	logic [DEPTH-1:0]         cell_hit;

	assign s_tready   = !m_valid_q || m_tready;
	assign accept     = s_tvalid && s_tready;
	assign mode       = mode_t'(s_tuser);
	assign is_full    = (count_q == CNT_W'(DEPTH));
	assign no_entries = (count_q == '0);

	always_comb begin
		ctrl.op    = OP_HOLD;
		ctrl.ident = s_tdata[15:0];
		ctrl.prio  = $signed(s_tdata[31:16]);
		count_nxt  = count_q;
		status     = ST_OK;
		head_ident = '0;
		head_prio  = '0;
		found      = 1'b0;
		case (mode)
			MODE_INSERT: begin
				if (is_full) begin
					status = ST_FULL;
				end else begin
					ctrl.op   = accept ? OP_INSERT : OP_HOLD;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			MODE_POP, MODE_PEEK: begin
				if (no_entries) begin
					status = ST_EMPTY;
				end else begin
					head_ident = cell_ident[0];
					head_prio  = cell_prio[0];
					if (mode == MODE_POP) begin
						ctrl.op   = accept ? OP_POP : OP_HOLD;
						count_nxt = count_q - CNT_W'(1);
					end
				end
			end
			MODE_FIND: begin
				found = |cell_hit;
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic                     left_ge;
		logic [IDENT_W-1:0]       left_ident;
		logic signed [PRIO_W-1:0] left_prio;
		logic [IDENT_W-1:0]       right_ident;
		logic signed [PRIO_W-1:0] right_prio;

		if (i == 0) begin : g_first
			assign left_ge    = 1'b0;
			assign left_ident = '0;
			assign left_prio  = '0;
		end else begin : g_inner
			assign left_ge    = cell_ge[i-1];
			assign left_ident = cell_ident[i-1];
			assign left_prio  = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_ident = '0;
			assign right_prio  = '0;
		end else begin : g_mid
			assign right_ident = cell_ident[i+1];
			assign right_prio  = cell_prio[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (IDX < count_q),
			.left_ge     (left_ge),
			.left_ident  (left_ident),
			.left_prio   (left_prio),
			.right_ident (right_ident),
			.right_prio  (right_prio),
			.ge          (cell_ge[i]),
			.hit         (cell_hit[i]),
			.ident       (cell_ident[i]),
			.prio        (cell_prio[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q   <= count_nxt;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {7'b0, (count_nxt == '0), COUNT_W'(count_nxt), found,
				status, head_prio, head_ident};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

### tb/tb_sorted_priority_queue.sv
// Testbench for the sorted priority queue: directed and random requests, every output beat checked.
module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int PHASE_ITEMS    = 400;
	localparam int HOLD_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic [IDENT_W-1:0]       head_ident;
		logic signed [PRIO_W-1:0] head_prio;
		status_t                  status;
		logic                     found;
		logic [COUNT_W-1:0]       entry_count;
		logic                     queue_empty;
	} outcome_t;

	class spq_scoreboard;
		logic [IDENT_W-1:0]       slot_ident [DEPTH];
		logic signed [PRIO_W-1:0] slot_prio [DEPTH];
		int                       fill;
		int                       errors;
		int                       beats;
		outcome_t                 awaited [$];

		function new();
			fill   = 0;
			errors = 0;
			beats  = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_field(string name, longint got, longint want);
			if (got != want)
				report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
					beats, name, got, want));
		endtask

		// Applies one accepted request to the shadow row and queues the beat it must give.
		function void note_request(mode_t m, logic [IDENT_W-1:0] id,
				logic signed [PRIO_W-1:0] pr);
			outcome_t o;
			int       pos;
			int       i;
			o.head_ident = '0;
			o.head_prio  = '0;
			o.status     = ST_OK;
			o.found      = 1'b0;
			case (m)
				MODE_INSERT: begin
					if (fill >= DEPTH) begin
						o.status = ST_FULL;
					end else begin
						// The new entry goes ahead of the first one with a priority not above its own.
						pos = fill;
						for (i = 0; i < fill; i++) begin
							if (pr >= slot_prio[i]) begin
								pos = i;
								break;
							end
						end
						for (i = fill; i > pos; i--) begin
							slot_ident[i] = slot_ident[i-1];
							slot_prio[i]  = slot_prio[i-1];
						end
						slot_ident[pos] = id;
						slot_prio[pos]  = pr;
						fill++;
					end
				end
				MODE_POP, MODE_PEEK: begin
					if (fill == 0) begin
						o.status = ST_EMPTY;
					end else begin
						o.head_ident = slot_ident[0];
						o.head_prio  = slot_prio[0];
						if (m == MODE_POP) begin
							for (i = 1; i < fill; i++) begin
								slot_ident[i-1] = slot_ident[i];
								slot_prio[i-1]  = slot_prio[i];
							end
							fill--;
						end
					end
				end
				default: begin
					for (i = 0; i < fill; i++)
						if (slot_ident[i] == id)
							o.found = 1'b1;
				end
			endcase
			o.entry_count = COUNT_W'(fill);
			o.queue_empty = (fill == 0);
			awaited.push_back(o);
		endfunction

		task check_result(logic [47:0] beat);
			outcome_t want;
			beats++;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("beat %0d arrived with no request waiting: %h",
					beats, beat));
				return;
			end
			want = awaited[0];
			awaited.delete(0);
			check_field("head_ident", beat[15:0], want.head_ident);
			check_field("head_prio", $signed(beat[31:16]), want.head_prio);
			check_field("status", beat[33:32], want.status);
			check_field("found", beat[34], want.found);
			check_field("entry_count", beat[39:35], want.entry_count);
			check_field("queue_empty", beat[40], want.queue_empty);
		endtask
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	spq_scoreboard sb;
	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	bit            hold_req       = 1'b0;
	bit            filling        = 1'b1;
	logic [15:0]   recent_ids [8] = '{default: '0};
	int            recent_wr      = 0;
	int            quiet_cycles   = 0;

	sorted_priority_queue #(.DEPTH(DEPTH)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offers one request, with random idle cycles ahead of it, and returns once it is taken.
	task automatic offer_request(mode_t m, logic [15:0] id, logic signed [15:0] pr);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= m;
		s_tdata  <= {pr, id};
		do @(posedge clk); while (!s_tready);
		sb.note_request(m, id, pr);
	endtask

	task automatic random_request();
		mode_t              m;
		logic [15:0]        id;
		logic signed [15:0] pr;
		int                 roll;
		// Swing between filling and draining so both the full and the empty queue come up often.
		if (filling && sb.fill == DEPTH && $urandom_range(3) == 0)
			filling = 1'b0;
		else if (!filling && sb.fill == 0 && $urandom_range(3) == 0)
			filling = 1'b1;
		else if ($urandom_range(49) == 0)
			filling = !filling;
		roll = $urandom_range(99);
		if (filling)
			m = (roll < 60) ? MODE_INSERT : (roll < 75) ? MODE_POP :
				(roll < 85) ? MODE_PEEK : MODE_FIND;
		else
			m = (roll < 20) ? MODE_INSERT : (roll < 70) ? MODE_POP :
				(roll < 85) ? MODE_PEEK : MODE_FIND;
		case ($urandom_range(3))
			0, 1: id = 16'($urandom);
			2:    id = 16'($urandom_range(15));
			default: id = recent_ids[$urandom_range(7)];
		endcase
		case ($urandom_range(3))
			0, 1: pr = 16'($urandom);
			2:    pr = 16'($signed($urandom_range(6)) - 3);
			default: begin
				case ($urandom_range(3))
					0: pr = 16'sh8000;
					1: pr = 16'sh7fff;
					2: pr = 16'sh0000;
					default: pr = -16'sd1;
				endcase
			end
		endcase
		if (m == MODE_INSERT) begin
			recent_ids[recent_wr] = id;
			recent_wr = (recent_wr + 1) % 8;
		end
		offer_request(m, id, pr);
	endtask

	task automatic directed_requests();
		offer_request(MODE_POP,    16'h0000, 16'sh0000);
		offer_request(MODE_PEEK,   16'hffff, 16'sh7fff);
		offer_request(MODE_FIND,   16'h0000, 16'sh0000);
		offer_request(MODE_INSERT, 16'hffff, 16'sh7fff);
		offer_request(MODE_INSERT, 16'h0000, 16'sh8000);
		offer_request(MODE_INSERT, 16'haaaa, 16'sh0000);
		// Same priority again: the newer entry must come out first.
		offer_request(MODE_INSERT, 16'h5555, 16'sh0000);
		offer_request(MODE_INSERT, 16'h0001, -16'sd1);
		offer_request(MODE_PEEK,   16'h1234, 16'sh1234);
		offer_request(MODE_FIND,   16'h0000, 16'sh8000);
		offer_request(MODE_FIND,   16'h0002, 16'sh7fff);
		offer_request(MODE_FIND,   16'hffff, 16'sh0000);
		repeat (5)
			offer_request(MODE_POP, 16'hbeef, 16'sh0000);
		offer_request(MODE_POP,    16'hffff, 16'shffff);
		offer_request(MODE_PEEK,   16'h0000, 16'sh0000);
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		directed_requests();
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1) ? 65 : (phase == 3) ? 32 : 0;
			recv_stall_pct = (phase == 2) ? 65 : (phase == 3) ? 32 : 0;
			// A long output stall while requests keep coming backs the block up to its input.
			if (phase == 0)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS)
				random_request();
		end
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** sorted_priority_queue: PASSED **");
		else
			$display("** sorted_priority_queue: FAILED **");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("** sorted_priority_queue: FAILED **");
			$finish;
		end
	end

endmodule
